// ===== rtl/hpa_pkg.sv =====
`default_nettype none
package hpa_pkg;

  // Input item command codes, carried in in_tuser.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_PICK  = 1'b1;

  // Field widths.
  localparam int SLOT_W  = 6;
  localparam int WAIT_W  = 16;
  localparam int BURST_W = 8;
  localparam int NUM_W   = WAIT_W + 1;
  localparam int PROD_W  = NUM_W + BURST_W;
  localparam int RATIO_W = 23;
  localparam int SCALE_W = 24;
  localparam int DIV_CW  = $clog2(RATIO_W);
  localparam int TDATA_W = 32;

  localparam int RATIO_SCALE = 100;

  // Input tdata layout, lowest bit first: slot, runnable, wait ticks, burst length.
  localparam int IN_SLOT_LSB  = 0;
  localparam int IN_RUN_BIT   = IN_SLOT_LSB + SLOT_W;
  localparam int IN_WAIT_LSB  = IN_RUN_BIT + 1;
  localparam int IN_BURST_LSB = IN_WAIT_LSB + WAIT_W;

  // Slot table word: {ready, wait, burst}.
  localparam int ENTRY_W = 1 + WAIT_W + BURST_W;

  typedef logic [ENTRY_W-1:0] hpa_entry_t;

  typedef struct packed {
    logic clr_we;
    logic item_we;
    logic fin_we;
    logic cnt_zero;
    logic cnt_inc;
    logic rd_en;
    logic best_clear;
    logic div_load;
    logic div_step;
    logic out_load;
  } hpa_cmd_t;

  typedef struct packed {
    logic have;
    logic last_slot;
    logic scan_end;
    logic div_end;
  } hpa_sts_t;

endpackage
`default_nettype wire

// ===== rtl/hpa_ram.sv =====
`default_nettype none
module hpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hpa_ctrl.sv =====
`default_nettype none
module hpa_ctrl
  import hpa_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  input  wire logic     in_tuser,
  output      logic     in_tready,
  output      logic     out_tvalid,
  input  wire logic     out_tready,
  output      hpa_cmd_t cmd,
  input  wire hpa_sts_t sts
);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_FIN  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_acc;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_CLR: begin
        cmd.clr_we  = 1'b1;
        cmd.cnt_inc = 1'b1;
        if (sts.last_slot) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == CMD_PICK) begin
            cmd.cnt_zero   = 1'b1;
            cmd.best_clear = 1'b1;
            state_nxt      = ST_SCAN;
          end else begin
            cmd.item_we = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        // The last slot read is still being compared in the cycle that sees scan_end.
        if (sts.scan_end) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.cnt_inc = 1'b1;
        end
      end
      ST_FIN: begin
        if (sts.have) begin
          cmd.fin_we   = 1'b1;
          cmd.div_load = 1'b1;
          cmd.cnt_zero = 1'b1;
          state_nxt    = ST_DIV;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        cmd.cnt_inc  = 1'b1;
        if (sts.div_end) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/hpa_dp.sv =====
`default_nettype none
module hpa_dp
  import hpa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire hpa_cmd_t           cmd,
  output      hpa_sts_t           sts,
  input  wire logic [TDATA_W-1:0] in_tdata,
  output      logic [TDATA_W-1:0] out_tdata,
  output      logic               out_tuser
);

  localparam int AW  = $clog2(SLOTS);
  localparam int CW0 = $clog2(SLOTS + 1);
  localparam int CW  = (CW0 > DIV_CW) ? CW0 : DIV_CW;

  logic [CW-1:0] cnt_r, cnt_nxt;

  // Input fields.
  logic [SLOT_W-1:0]  in_slot;
  logic               in_run;
  logic [WAIT_W-1:0]  in_wait;
  logic [BURST_W-1:0] in_burst, burst_fix;
  logic [AW+SLOT_W-1:0] slot_ext;
  logic               slot_ok;

  // Table port signals.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  hpa_entry_t       ram_wdata;
  hpa_entry_t       rd_word;

  // Scan state.
  logic              ev_v_r;
  logic              have_r;
  logic [AW-1:0]     ev_idx_r;
  logic [AW-1:0]     best_idx_r;
  logic [NUM_W-1:0]  top_num_r;
  logic [BURST_W-1:0] top_den_r;
  logic              r_ready;
  logic [WAIT_W-1:0] r_wait;
  logic [BURST_W-1:0] r_burst;
  logic [NUM_W-1:0]  r_num;
  logic [PROD_W-1:0] lhs, rhs;
  logic              take;

  // Divider state.
  logic [RATIO_W-1:0] quo_r;
  logic [BURST_W-1:0] rem_r;
  logic [SCALE_W-1:0] dividend;
  logic [BURST_W:0]   trial, diff;
  logic               ge;

  // Result registers.
  logic               out_found_r;
  logic [SLOT_W-1:0]  out_slot_r;
  logic [RATIO_W-1:0] out_ratio_r;
  logic [AW+SLOT_W-1:0] best_ext;

  assign in_slot   = in_tdata[IN_SLOT_LSB +: SLOT_W];
  assign in_run    = in_tdata[IN_RUN_BIT];
  assign in_wait   = in_tdata[IN_WAIT_LSB +: WAIT_W];
  assign in_burst  = in_tdata[IN_BURST_LSB +: BURST_W];
  // A zero burst is kept as one so the rounding divide stays defined.
  assign burst_fix = (in_burst == '0) ? BURST_W'(1) : in_burst;
  assign slot_ext  = {{AW{1'b0}}, in_slot};
  assign slot_ok   = (32'(in_slot) < 32'(SLOTS));

  assign sts.have      = have_r;
  assign sts.last_slot = (cnt_r == CW'(SLOTS - 1));
  assign sts.scan_end  = (cnt_r == CW'(SLOTS));
  assign sts.div_end   = (cnt_r == CW'(RATIO_W - 1));

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.cnt_zero) begin
      cnt_nxt = '0;
    end else if (cmd.cnt_inc) begin
      cnt_nxt = cnt_r + CW'(1);
    end
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    if (cmd.clr_we) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[AW-1:0];
    end else if (cmd.fin_we) begin
      // The picked slot is now running: its entry goes back to not ready.
      ram_we    = 1'b1;
      ram_waddr = best_idx_r;
    end else if (cmd.item_we && slot_ok) begin
      ram_we    = 1'b1;
      ram_waddr = slot_ext[AW-1:0];
      ram_wdata = {in_run, in_wait, burst_fix};
    end
  end

  hpa_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (cnt_r[AW-1:0]),
    .rdata (rd_word)
  );

  // Compare ratios by cross-multiplication; only a strictly larger one replaces the best.
  assign r_ready = rd_word[ENTRY_W-1];
  assign r_wait  = rd_word[BURST_W +: WAIT_W];
  assign r_burst = rd_word[BURST_W-1:0];
  assign r_num   = NUM_W'(r_wait) + NUM_W'(r_burst);
  assign lhs     = PROD_W'(r_num) * PROD_W'(top_den_r);
  assign rhs     = PROD_W'(top_num_r) * PROD_W'(r_burst);
  assign take    = ev_v_r && r_ready && (!have_r || (lhs > rhs));

  assign dividend = SCALE_W'(top_num_r) * SCALE_W'(RATIO_SCALE)
                  + SCALE_W'(top_den_r >> 1);
  assign trial    = {rem_r, quo_r[RATIO_W-1]};
  assign diff     = trial - {1'b0, top_den_r};
  assign ge       = (trial >= {1'b0, top_den_r});

  assign best_ext = {{SLOT_W{1'b0}}, best_idx_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      ev_v_r <= 1'b0;
      have_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      ev_v_r <= cmd.rd_en;
      if (cmd.best_clear) begin
        have_r <= 1'b0;
      end else if (take) begin
        have_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    ev_idx_r <= cnt_r[AW-1:0];
    if (take) begin
      best_idx_r <= ev_idx_r;
      top_num_r  <= r_num;
      top_den_r  <= r_burst;
    end
    if (cmd.div_load) begin
      quo_r <= dividend[RATIO_W-1:0];
      rem_r <= '0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[RATIO_W-2:0], ge};
      rem_r <= ge ? diff[BURST_W-1:0] : trial[BURST_W-1:0];
    end
    if (cmd.out_load) begin
      out_found_r <= have_r;
      out_slot_r  <= have_r ? best_ext[SLOT_W-1:0] : '0;
      out_ratio_r <= have_r ? quo_r : '0;
    end
  end

  assign out_tdata = {{(TDATA_W - RATIO_W - SLOT_W){1'b0}}, out_ratio_r, out_slot_r};
  assign out_tuser = out_found_r;

endmodule
`default_nettype wire

// ===== rtl/hrrn_pick_arbiter_unit.sv =====
`default_nettype none
// Channel | Direction | Beat contents
// in_*    | input     | tuser: cmd; tdata: slot, runnable, wait ticks, burst length
// out_*   | output    | tuser: found; tdata: picked_slot, ratio_x100
//
// A write beat produces no output beat.
// A pick reads the table once per slot through the slot RAM's single read port,
// then runs a 23-step bit-serial rounding divide.
// A pick that finds no ready slot skips the divide.
// After reset the slot table is cleared one entry per cycle, with in_tready low.
// A waiting result is held in the output register while the next input beat is accepted.
module hrrn_pick_arbiter_unit
  import hpa_pkg::*;
#(
  parameter int SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output      logic               in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,   // [5:0] slot, [6] runnable, [22:7] wait ticks,
                                              // [30:23] burst length
  input  wire logic               in_tuser,   // [0] cmd
  output      logic               out_tvalid,
  input  wire logic               out_tready,
  output      logic [TDATA_W-1:0] out_tdata,  // [5:0] picked_slot, [28:6] ratio_x100
  output      logic               out_tuser   // [0] found
);

  hpa_cmd_t cmd;
  hpa_sts_t sts;

  hpa_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tuser   (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  hpa_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

endmodule
`default_nettype wire

// ===== tb/hrrn_pick_checker.sv =====
module hrrn_pick_checker
  import hpa_pkg::*;
#(
  parameter int NUM_SLOTS = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  input  wire logic               in_tready,
  input  wire logic [TDATA_W-1:0] in_tdata,
  input  wire logic               in_tuser,
  input  wire logic               out_tvalid,
  input  wire logic               out_tready,
  input  wire logic [TDATA_W-1:0] out_tdata,
  input  wire logic               out_tuser,
  output int                      fail_count,
  output int                      pending
);

  typedef struct packed {
    logic               found;
    logic [SLOT_W-1:0]  slot;
    logic [RATIO_W-1:0] ratio;
  } pick_result_t;

  // Shadow copy of the slot table.
  bit   [NUM_SLOTS-1:0] slot_ready;
  logic [WAIT_W-1:0]    slot_wait  [NUM_SLOTS];
  logic [BURST_W-1:0]   slot_burst [NUM_SLOTS];

  pick_result_t picks_due[$];
  int           err_count = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  // Highest response ratio over the ready slots. The cross products only
  // replace the best on a strictly greater ratio, so the lowest slot wins ties.
  function automatic pick_result_t choose_slot();
    pick_result_t       res;
    logic               have;
    int unsigned        best;
    logic [NUM_W-1:0]   num;
    logic [NUM_W-1:0]   top_num;
    logic [BURST_W-1:0] top_den;
    logic [PROD_W-1:0]  lhs;
    logic [PROD_W-1:0]  rhs;
    logic [SCALE_W-1:0] scaled;
    res     = '0;
    have    = 1'b0;
    best    = 0;
    top_num = '0;
    top_den = BURST_W'(1);
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (slot_ready[i]) begin
        num = NUM_W'(slot_wait[i]) + NUM_W'(slot_burst[i]);
        lhs = PROD_W'(num) * PROD_W'(top_den);
        rhs = PROD_W'(top_num) * PROD_W'(slot_burst[i]);
        if (!have || lhs > rhs) begin
          have    = 1'b1;
          best    = i;
          top_num = num;
          top_den = slot_burst[i];
        end
      end
    end
    if (have) begin
      scaled = (SCALE_W'(top_num) * SCALE_W'(RATIO_SCALE) + SCALE_W'(top_den >> 1))
               / SCALE_W'(top_den);
      res.found = 1'b1;
      res.slot  = best[SLOT_W-1:0];
      res.ratio = scaled[RATIO_W-1:0];
    end
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pick_result_t got;
    pick_result_t want;
    logic [SLOT_W-1:0]  wr_slot;
    logic [BURST_W-1:0] wr_burst;
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        slot_ready[i] = 1'b0;
        slot_wait[i]  = '0;
        slot_burst[i] = BURST_W'(1);
      end
      picks_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.found = out_tuser;
        got.slot  = out_tdata[SLOT_W-1:0];
        got.ratio = out_tdata[SLOT_W +: RATIO_W];
        if (picks_due.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual found=%0d slot=%0d ratio=%0d",
                   $time, got.found, got.slot, got.ratio);
          err_count++;
        end else begin
          want = picks_due.pop_front();
          check_field("found", want.found, got.found);
          check_field("picked_slot", want.slot, got.slot);
          check_field("ratio_x100", want.ratio, got.ratio);
        end
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser == CMD_WRITE) begin
          wr_slot  = in_tdata[IN_SLOT_LSB +: SLOT_W];
          wr_burst = in_tdata[IN_BURST_LSB +: BURST_W];
          if (int'(wr_slot) < NUM_SLOTS) begin
            slot_ready[wr_slot] = in_tdata[IN_RUN_BIT];
            slot_wait[wr_slot]  = in_tdata[IN_WAIT_LSB +: WAIT_W];
            // A zero burst is kept as one so the divide stays defined.
            slot_burst[wr_slot] = (wr_burst == 0) ? BURST_W'(1) : wr_burst;
          end
        end else begin
          want = choose_slot();
          if (want.found) slot_ready[want.slot] = 1'b0;
          picks_due.push_back(want);
        end
      end
    end
    fail_count <= err_count;
    pending    <= picks_due.size();
  end

endmodule

// ===== tb/tb_hrrn_pick_arbiter_unit.sv =====
module tb_hrrn_pick_arbiter_unit
  import hpa_pkg::*;
;

  localparam int NUM_SLOTS  = 64;
  localparam int ITEM_GOAL  = 1850;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN      = 200;

  logic               clk        = 1'b0;
  logic               rst_n      = 1'b0;
  logic               in_tvalid  = 1'b0;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata   = '0;
  logic               in_tuser   = CMD_WRITE;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic               out_tuser;

  int fail_count;
  int pending;
  int items_sent = 0;
  int beats_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  hrrn_pick_arbiter_unit #(
    .SLOTS(NUM_SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  hrrn_pick_checker #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // The receiver switches between always ready, coin flips, long stalls and a
  // fixed three-of-eight pattern.
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(32, 256);
    end else begin
      rx_left--;
    end
    rx_tick++;
    case (rx_mode)
      0: begin
        out_tready <= 1'b1;
      end
      1: begin
        out_tready <= 1'($urandom_range(0, 1));
      end
      2: begin
        out_tready <= ($urandom_range(0, 19) == 0);
      end
      default: begin
        out_tready <= ((rx_tick % 8) < 3);
      end
    endcase
  end

  // Ends the run when neither channel has moved a beat for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Presents one beat, waits for it to be taken, then maybe opens a gap that
  // ends the current burst.
  task automatic send_beat(input logic cmd, input logic [TDATA_W-1:0] data);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if (beats_left == 0) begin
      beats_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end else begin
      beats_left--;
    end
  endtask

  task automatic write_slot(input logic [SLOT_W-1:0] slot, input logic run,
                            input logic [WAIT_W-1:0] wait_t, input logic [BURST_W-1:0] burst);
    send_beat(CMD_WRITE, {1'b0, burst, wait_t, run, slot});
  endtask

  // The unused fields of a pick carry random bits.
  task automatic pick();
    send_beat(CMD_PICK, {1'b0, 31'($urandom())});
  endtask

  initial begin : stimulus
    int n_writes;
    int n_picks;
    int slot_span;
    logic [SLOT_W-1:0]  w_slot;
    logic               w_run;
    logic [WAIT_W-1:0]  w_wait;
    logic [BURST_W-1:0] w_burst;
    int sel;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table, extremes of wait and burst, zero burst.
    pick();
    write_slot(6'd0, 1'b1, 16'd0, 8'd1);
    write_slot(6'd63, 1'b1, 16'hFFFF, 8'd1);
    write_slot(6'd10, 1'b1, 16'hFFFF, 8'd255);
    write_slot(6'd20, 1'b1, 16'd100, 8'd0);
    pick();
    pick();
    // Equal ratios on two slots, plus a large one that is not runnable.
    write_slot(6'd6, 1'b1, 16'd20, 8'd20);
    write_slot(6'd5, 1'b1, 16'd10, 8'd10);
    write_slot(6'd4, 1'b0, 16'hFFFF, 8'd1);
    pick();
    pick();
    pick();
    pick();
    pick();
    // Rounding down and rounding up on an exact half.
    write_slot(6'd7, 1'b1, 16'd1, 8'd3);
    write_slot(6'd8, 1'b1, 16'd1, 8'd200);
    write_slot(6'd9, 1'b1, 16'h5555, 8'hAA);
    write_slot(6'd9, 1'b0, 16'hAAAA, 8'h55);
    pick();
    pick();
    pick();
    pick();

    // Episodes of loading slots followed by a few picks.
    while (items_sent < ITEM_GOAL) begin
      n_writes  = $urandom_range(1, 12);
      n_picks   = $urandom_range(1, 6);
      slot_span = ($urandom_range(0, 3) == 0) ? 4 : NUM_SLOTS;
      repeat (n_writes) begin
        w_slot = SLOT_W'($urandom_range(0, slot_span - 1));
        w_run  = ($urandom_range(0, 3) != 0);
        sel    = $urandom_range(0, 15);
        if (sel == 0) w_burst = 8'd0;
        else if (sel < 3) w_burst = 8'd1;
        else if (sel < 5) w_burst = 8'd255;
        else w_burst = BURST_W'($urandom_range(1, 255));
        sel = $urandom_range(0, 7);
        if (sel < 2) w_wait = WAIT_W'($urandom_range(0, 65535));
        else if (sel < 4) w_wait = WAIT_W'($urandom_range(0, 15));
        else if (sel == 4) w_wait = 16'hFFFF;
        // Whole multiples of the burst give many equal ratios.
        else w_wait = WAIT_W'(w_burst) * WAIT_W'($urandom_range(0, 3));
        write_slot(w_slot, w_run, w_wait, w_burst);
      end
      repeat (n_picks) pick();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hpa_pkg.sv
rtl/hpa_ram.sv
rtl/hpa_ctrl.sv
rtl/hpa_dp.sv
rtl/hrrn_pick_arbiter_unit.sv
tb/hrrn_pick_checker.sv
tb/tb_hrrn_pick_arbiter_unit.sv
